FILE: rtl/rgbk_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution package
// Shared widths, codes, reset values and payload types of the convolution block.
// ----------------------------------------------------------------------------
package rgbk_pkg;

    localparam int MAX_WIDTH_DEF = 1024;  // default line store depth
    localparam int MAX_HEIGHT    = 1024;  // largest frame height
    localparam int MIN_GEOM      = 3;     // smallest width or height
    localparam int GEOM_W        = 11;    // width of the geometry registers
    localparam int MODE_W        = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int ROW_W         = 10;    // row position register
    localparam int POS_W         = 10;    // center_row and center_col
    localparam int SUM_W         = 12;    // signed channel sum
    localparam int CHAN_W        = 8;
    localparam int OUT_DEPTH     = 4;     // result queue entries

    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd3;
    localparam logic [GEOM_W-1:0] WIDTH_RESET  = 11'd512;
    localparam logic [GEOM_W-1:0] HEIGHT_RESET = 11'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BLUR     = 3'd0,
        MODE_SHARPEN  = 3'd1,
        MODE_SOBEL_H  = 3'd2,
        MODE_IDENTITY = 3'd3,
        MODE_EMBOSS   = 3'd4
    } filter_mode_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // Position information that travels with a pixel down the pipeline.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] center_col;
        logic [POS_W-1:0] center_row;
    } pos_meta_t;

    typedef struct packed {
        logic                    last;
        logic [POS_W-1:0]        center_col;
        logic [POS_W-1:0]        center_row;
        logic signed [SUM_W-1:0] blue_sum;
        logic signed [SUM_W-1:0] green_sum;
        logic signed [SUM_W-1:0] red_sum;
    } result_t;

endpackage

FILE: rtl/rgbk_line_buf.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution line buffer
// Two row memories holding the previous two image rows, with registered reads.
// ----------------------------------------------------------------------------
module rgbk_line_buf
    import rgbk_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int ADDR_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    addr,
    input  pixel_t               wr_pix,
    output pixel_t               up_pix,
    output pixel_t               mid_pix
);
    pixel_t upper_mem  [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];

    pixel_t              up_rd_reg;
    pixel_t              mid_rd_reg;
    logic                pend_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;

    // The upper row is written in the cycle after the read, once the middle row
    // value that moves up is known. A request at the same column in that cycle
    // takes the pending value directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pend_addr_reg    <= addr;
            mid_rd_reg       <= middle_mem[addr];
            middle_mem[addr] <= wr_pix;
            if (pend_reg && (pend_addr_reg == addr)) begin
                up_rd_reg <= mid_rd_reg;
            end else begin
                up_rd_reg <= upper_mem[addr];
            end
        end
        if (pend_reg) begin
            upper_mem[pend_addr_reg] <= mid_rd_reg;
        end
    end

    assign up_pix  = up_rd_reg;
    assign mid_pix = mid_rd_reg;

endmodule

FILE: rtl/rgbk_window.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution window
// Holds the 3x3 pixel window and forms the three kernel sums of its center.
// ----------------------------------------------------------------------------
module rgbk_window
    import rgbk_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [MODE_W-1:0] filter_mode,
    input  logic              shift_valid,
    input  pixel_t            up_pix,
    input  pixel_t            mid_pix,
    input  pixel_t            new_pix,
    input  pos_meta_t         shift_meta,
    output logic              push,
    output result_t           push_data
);
    pixel_t    win_reg [9];
    logic      c_valid_reg;
    pos_meta_t c_meta_reg;

    logic [8:0][CHAN_W-1:0] red_v;
    logic [8:0][CHAN_W-1:0] green_v;
    logic [8:0][CHAN_W-1:0] blue_v;

    // Integer weights; modes without a kernel of their own act as identity.
    function automatic logic signed [3:0] tap_weight(input logic [MODE_W-1:0] mode,
                                                      input int k);
        logic signed [3:0] w;
        w = 4'sd0;
        case (mode)
            MODE_SHARPEN: begin
                case (k)
                    1, 3, 5, 7: w = -4'sd1;
                    4:          w = 4'sd5;
                    default:    w = 4'sd0;
                endcase
            end
            MODE_SOBEL_H: begin
                case (k)
                    0, 2:    w = 4'sd1;
                    1:       w = 4'sd2;
                    6, 8:    w = -4'sd1;
                    7:       w = -4'sd2;
                    default: w = 4'sd0;
                endcase
            end
            MODE_EMBOSS: begin
                case (k)
                    0:          w = -4'sd2;
                    1, 3:       w = -4'sd1;
                    4, 5, 7:    w = 4'sd1;
                    8:          w = 4'sd2;
                    default:    w = 4'sd0;
                endcase
            end
            default: begin
                w = (k == 4) ? 4'sd1 : 4'sd0;
            end
        endcase
        return w;
    endfunction

    // Blur weights 1, 2 and 4 sixteenths become right shifts of 4, 3 and 2.
    function automatic int blur_shift(input int k);
        int s;
        case (k)
            4:          s = 2;
            1, 3, 5, 7: s = 3;
            default:    s = 4;
        endcase
        return s;
    endfunction

    function automatic logic signed [SUM_W-1:0] chan_sum(input logic [MODE_W-1:0] mode,
                                                          input logic [8:0][CHAN_W-1:0] v);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] term;
        acc = '0;
        for (int k = 0; k < 9; k++) begin
            if (mode == MODE_BLUR) begin
                term = $signed({{(SUM_W-CHAN_W){1'b0}}, v[k] >> blur_shift(k)});
            end else begin
                term = $signed({{(SUM_W-CHAN_W){1'b0}}, v[k]}) * tap_weight(mode, k);
            end
            acc = acc + term;
        end
        return acc;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= shift_valid && shift_meta.emit;
            if (shift_valid) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up_pix;
                win_reg[5] <= mid_pix;
                win_reg[8] <= new_pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_valid) begin
            c_meta_reg <= shift_meta;
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            red_v[k]   = win_reg[k].red;
            green_v[k] = win_reg[k].green;
            blue_v[k]  = win_reg[k].blue;
        end
        push_data.red_sum    = chan_sum(filter_mode, red_v);
        push_data.green_sum  = chan_sum(filter_mode, green_v);
        push_data.blue_sum   = chan_sum(filter_mode, blue_v);
        push_data.center_row = c_meta_reg.center_row;
        push_data.center_col = c_meta_reg.center_col;
        push_data.last       = c_meta_reg.last;
    end

    assign push = c_valid_reg;

endmodule

FILE: rtl/rgbk_out_fifo.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution result queue
// Small queue that holds finished results while the receiver stalls.
// ----------------------------------------------------------------------------
module rgbk_out_fifo
    import rgbk_pkg::*;
#(
    parameter int DEPTH  = OUT_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  result_t           push_data,
    input  logic              pop,
    output logic              out_valid,
    output result_t           out_data,
    output logic [CNT_W-1:0]  count
);
    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: rtl/rgb_3x3_kernel_convolution.sv
// ----------------------------------------------------------------------------
// RGB 3x3 kernel convolution
// Raster-order RGB pixel stream in, 3x3 kernel sums of interior pixels out.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream, one per request, in raster order; s_tuser
// marks the first pixel of a frame and returns the position to row 0, col 0.
// Without it the position wraps after the last pixel of a frame.
// For every pixel at row >= 2 and col >= 2 one result leaves on the m_ stream:
// the signed kernel sums of the three channels for the window center, its
// row and column, and m_tlast on the last interior pixel of the frame.
// Border pixels give no result.
// Kernel, width and height are set through the cfg_ write channel while the
// stream is idle: index 0 kernel mode, 1 frame width, 2 frame height.
// A result passes the line store read register, the window register and
// the result queue before it is offered.
// Throughput: one pixel per cycle while s_tready stays high; each line store
// has one read and one write per cycle, which sets that rate.
// Reset clears the position, the window and the result queue and loads mode
// identity, width 512 and height 512. When the receiver stalls, results wait
// in a four-entry queue and s_tready drops once it could fill.
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_convolution
    import rgbk_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,    // red_in, green_in, blue_in
    input  logic                  s_tuser,    // start_of_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,    // red_sum, green_sum, blue_sum,
                                              // center_row, center_col
    output logic                  m_tlast,    // last_of_frame
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [GEOM_W-1:0]     cfg_data
);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > GEOM_W) ? WW : GEOM_W;
    localparam int CCW   = (COL_W > POS_W) ? COL_W : POS_W;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [MODE_W-1:0]  mode_reg;
    logic [GEOM_W-1:0]  width_reg;
    logic [GEOM_W-1:0]  height_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_next;

    logic               b_valid_reg;
    pixel_t             b_pix_reg;
    pos_meta_t          b_meta_reg;

    logic               s_fire;
    logic               cfg_fire;
    pixel_t             in_pix;
    pos_meta_t          pos_meta;

    logic [EW-1:0]      fw_ext;
    logic [WW-1:0]      w_eff;
    logic [GEOM_W-1:0]  h_eff;
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [ROW_W:0]     row_step;
    logic               col_wrap;
    logic [CCW-1:0]     col_minus;

    pixel_t             up_pix;
    pixel_t             mid_pix;
    logic               win_push;
    result_t            win_data;
    result_t            out_data;
    logic [CNT_W-1:0]   fifo_count;
    logic [CNT_W:0]     in_flight;

    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign in_pix.red   = s_tdata[7:0];
    assign in_pix.green = s_tdata[15:8];
    assign in_pix.blue  = s_tdata[23:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_fire) begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry, clamped to what the line stores and rows can hold.
    always_comb begin
        fw_ext = EW'(width_reg);
        if (fw_ext < EW'(MIN_GEOM)) begin
            w_eff = WW'(MIN_GEOM);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
        if (height_reg < GEOM_W'(MIN_GEOM)) begin
            h_eff = GEOM_W'(MIN_GEOM);
        end else if (height_reg > GEOM_W'(MAX_HEIGHT)) begin
            h_eff = GEOM_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    always_comb begin
        col_cur   = s_tuser ? '0 : col_reg;
        row_cur   = s_tuser ? '0 : row_reg;
        col_inc   = {1'b0, col_cur} + 1'b1;
        row_inc   = {1'b0, row_cur} + 1'b1;
        col_wrap  = col_inc >= (COL_W+1)'(w_eff);
        row_step  = col_wrap ? row_inc : {1'b0, row_cur};
        col_next  = col_wrap ? '0 : col_inc[COL_W-1:0];
        row_next  = (GEOM_W'(row_step) >= h_eff) ? '0 : row_step[ROW_W-1:0];
        col_minus = CCW'(col_cur) - CCW'(1);

        pos_meta.emit       = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        pos_meta.last       = (GEOM_W'(row_inc) == h_eff) &&
                              (col_inc == (COL_W+1)'(w_eff));
        pos_meta.center_row = row_cur - 1'b1;
        pos_meta.center_col = col_minus[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= s_fire;
            if (s_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            b_pix_reg  <= in_pix;
            b_meta_reg <= pos_meta;
        end
    end

    rgbk_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .addr    (col_cur),
        .wr_pix  (in_pix),
        .up_pix  (up_pix),
        .mid_pix (mid_pix)
    );

    rgbk_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .filter_mode (mode_reg),
        .shift_valid (b_valid_reg),
        .up_pix      (up_pix),
        .mid_pix     (mid_pix),
        .new_pix     (b_pix_reg),
        .shift_meta  (b_meta_reg),
        .push        (win_push),
        .push_data   (win_data)
    );

    rgbk_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (win_push),
        .push_data (win_data),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    // Every pixel in the pipeline may still produce a result, so the queue
    // must keep a free entry for each of them.
    assign in_flight = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(b_valid_reg) +
                       (CNT_W+1)'(win_push);
    assign s_tready  = in_flight < (CNT_W+1)'(OUT_DEPTH);

    assign m_tdata = {out_data.center_col, out_data.center_row, out_data.blue_sum,
                      out_data.green_sum, out_data.red_sum};
    assign m_tlast = out_data.last;

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        win_push |-> (fifo_count < CNT_W'(OUT_DEPTH) || m_tready))
        else $error("result queue overflow");

    a_result_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        win_push |-> (win_data.center_row != '0 && win_data.center_col != '0))
        else $error("result produced for a border pixel");

    a_interior_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && pos_meta.emit) |-> ##2 win_push)
        else $error("interior pixel produced no result");
`endif

endmodule

FILE: test/rgb_3x3_kernel_convolution_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB 3x3 kernel convolution testbench
// Streams raster-order RGB frames into the block under a range of kernel
// modes and frame geometries. The block's result stream is checked field by
// field against an in-bench model of the line stores, window and kernels.
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_convolution_test;
    import rgbk_pkg::*;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any accepted request
    localparam int SETTLE_CYCLES = 8;     // lets the pipeline run dry
    localparam int ITEM_TARGET   = 1400;
    localparam int PRIME_WIDTH   = 12;    // fills line stores before a wide row
    localparam int MODE_CODES    = 1 << MODE_W;

    typedef struct packed {
        logic   sof;
        pixel_t color;
    } pixel_request_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [55:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = CFG_MODE;
    logic [GEOM_W-1:0] cfg_data  = '0;

    pixel_request_t pixel_queue[$];
    result_t        conv_expected[$];
    pixel_request_t driven_pixel;

    // Settings as the block holds them, updated on each register write.
    logic [MODE_W-1:0] mode_shadow   = MODE_RESET;
    logic [GEOM_W-1:0] width_shadow  = WIDTH_RESET;
    logic [GEOM_W-1:0] height_shadow = HEIGHT_RESET;

    bit [23:0] upper_line [MAX_WIDTH_DEF];
    bit [23:0] middle_line [MAX_WIDTH_DEF];
    bit [23:0] window_px [9];
    int        row_pos = 0;
    int        col_pos = 0;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int queued_pixels   = 0;
    int accepted_pixels = 0;
    int checked_results = 0;
    int register_writes = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    rgb_3x3_kernel_convolution i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int clamp_geom(logic [GEOM_W-1:0] raw, int top);
        if (raw < MIN_GEOM) return MIN_GEOM;
        if (raw > top) return top;
        return raw;
    endfunction

    // Window taps are numbered row by row; taps 0..2 see the oldest image row.
    function automatic int kernel_tap(logic [MODE_W-1:0] mode, int k);
        case (mode)
            MODE_BLUR: begin
                case (k)
                    4:          return 4;
                    1, 3, 5, 7: return 2;
                    default:    return 1;
                endcase
            end
            MODE_SHARPEN: begin
                case (k)
                    4:          return 5;
                    1, 3, 5, 7: return -1;
                    default:    return 0;
                endcase
            end
            MODE_SOBEL_H: begin
                case (k)
                    0, 2:    return 1;
                    1:       return 2;
                    6, 8:    return -1;
                    7:       return -2;
                    default: return 0;
                endcase
            end
            MODE_EMBOSS: begin
                case (k)
                    0:       return -2;
                    1, 3:    return -1;
                    4, 5, 7: return 1;
                    8:       return 2;
                    default: return 0;
                endcase
            end
            // Identity, and the unused codes that fall back to it.
            default: return (k == 4) ? 1 : 0;
        endcase
    endfunction

    function automatic logic signed [SUM_W-1:0] window_sum(logic [MODE_W-1:0] mode, int chan);
        int acc;
        int v;
        int k;
        acc = 0;
        for (k = 0; k < 9; k++) begin
            v = window_px[k][8*chan +: 8];
            // Blur truncates each tap to whole units before summing.
            if (mode == MODE_BLUR)
                acc += (v * kernel_tap(mode, k)) / 16;
            else
                acc += v * kernel_tap(mode, k);
        end
        return acc[SUM_W-1:0];
    endfunction

    task automatic convolve_pixel(input pixel_request_t px);
        int        w_eff;
        int        h_eff;
        int        row;
        int        col;
        int        k;
        bit [23:0] two_up;
        bit [23:0] one_up;
        result_t   res;
        w_eff = clamp_geom(width_shadow, MAX_WIDTH_DEF);
        h_eff = clamp_geom(height_shadow, MAX_HEIGHT);
        if (px.sof) begin
            row_pos = 0;
            col_pos = 0;
        end
        row = row_pos;
        col = col_pos;
        two_up = upper_line[col];
        one_up = middle_line[col];
        upper_line[col]  = one_up;
        middle_line[col] = px.color;
        for (k = 0; k < 9; k += 3) begin
            window_px[k]     = window_px[k + 1];
            window_px[k + 1] = window_px[k + 2];
        end
        window_px[2] = two_up;
        window_px[5] = one_up;
        window_px[8] = px.color;
        if (row >= 2 && col >= 2) begin
            res.red_sum    = window_sum(mode_shadow, 0);
            res.green_sum  = window_sum(mode_shadow, 1);
            res.blue_sum   = window_sum(mode_shadow, 2);
            res.center_row = POS_W'(row - 1);
            res.center_col = POS_W'(col - 1);
            res.last       = (row == h_eff - 1) && (col == w_eff - 1);
            conv_expected.push_back(res);
        end
        col++;
        if (col >= w_eff) begin
            col = 0;
            row++;
        end
        if (row >= h_eff) row = 0;
        row_pos = row;
        col_pos = col;
    endtask

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Pixel driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                convolve_pixel(driven_pixel);
                accepted_pixels++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven_pixel = pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= driven_pixel.color;
                    s_tuser  <= driven_pixel.sof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (conv_expected.size() == 0) begin
                    $error("result with none pending: center_row %0d, center_col %0d",
                           m_tdata[45:36], m_tdata[55:46]);
                    mismatches++;
                end else begin
                    want = conv_expected.pop_front();
                    check_field("red_sum", want.red_sum, $signed(m_tdata[11:0]));
                    check_field("green_sum", want.green_sum, $signed(m_tdata[23:12]));
                    check_field("blue_sum", want.blue_sum, $signed(m_tdata[35:24]));
                    check_field("center_row", want.center_row, m_tdata[45:36]);
                    check_field("center_col", want.center_col, m_tdata[55:46]);
                    check_field("last_of_frame", want.last, m_tlast);
                    checked_results++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("rgb_3x3_kernel_convolution verification failed");
        $finish;
    end

    task automatic write_register(input cfg_index_t idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= GEOM_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:  mode_shadow   = MODE_W'(value);
            CFG_WIDTH: width_shadow  = GEOM_W'(value);
            default:   height_shadow = GEOM_W'(value);
        endcase
        register_writes++;
    endtask

    // Waits until every pixel is in and every result is out, then lets the
    // pipeline run dry before the settings may change.
    task automatic settle;
        while (accepted_pixels != queued_pixels || conv_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void set_idling;
        if (queued_pixels < ITEM_TARGET / 3) begin
            send_idle_pct = 6;
            recv_idle_pct = 59;
        end else if (queued_pixels < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 59;
            recv_idle_pct = 6;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // A stray frame start now and then only where the geometry stays put.
    function automatic void queue_pixels(int count, logic sof_first, logic extremes_only,
                                         logic noisy);
        pixel_request_t px;
        int             i;
        for (i = 0; i < count; i++) begin
            px.sof = (i == 0) ? sof_first : (noisy && $urandom_range(149) == 0);
            if (extremes_only || $urandom_range(3) == 0) begin
                px.color.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                px.color.green = $urandom_range(1) ? 8'hFF : 8'h00;
                px.color.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end else begin
                px.color = 24'($urandom);
            end
            pixel_queue.push_back(px);
        end
        queued_pixels += count;
    endfunction

    function automatic int random_mode;
        if ($urandom_range(9) < 8) return $urandom_range(MODE_EMBOSS);
        return $urandom_range(MODE_CODES - 1, MODE_EMBOSS + 1);
    endfunction

    task automatic random_phase;
        int   w_raw;
        int   h_raw;
        int   w_eff;
        int   h_eff;
        int   len;
        logic sof;
        write_register(CFG_MODE, random_mode());
        w_raw = $urandom_range(10, MIN_GEOM);
        if ($urandom_range(9) == 0) w_raw = $urandom_range(MIN_GEOM - 1);
        h_raw = $urandom_range(8, MIN_GEOM);
        case ($urandom_range(9))
            0:       h_raw = $urandom_range(MIN_GEOM - 1);
            1:       h_raw = $urandom_range((1 << GEOM_W) - 1, MAX_HEIGHT + 1);
            2:       h_raw = MAX_HEIGHT;
            default: ;
        endcase
        write_register(CFG_WIDTH, w_raw);
        write_register(CFG_HEIGHT, h_raw);
        w_eff = clamp_geom(GEOM_W'(w_raw), MAX_WIDTH_DEF);
        h_eff = clamp_geom(GEOM_W'(h_raw), MAX_HEIGHT);
        sof = 1'b1;
        repeat ($urandom_range(3, 1)) begin
            len = w_eff * ((h_eff <= 8) ? h_eff : $urandom_range(8, MIN_GEOM));
            if ($urandom_range(7) == 0) len = $urandom_range(len - 1, 1);
            queue_pixels(len, sof, 1'b0, 1'b1);
            // A frame that was cut short must be restarted explicitly.
            sof = (len != w_eff * h_eff) || $urandom_range(1);
        end
        settle();
    endtask

    // Shrinks the geometry in the middle of a frame, past its third row.
    task automatic shrink_phase;
        int w;
        int h;
        w = $urandom_range(10, 6);
        h = $urandom_range(8, 5);
        write_register(CFG_MODE, random_mode());
        write_register(CFG_WIDTH, w);
        write_register(CFG_HEIGHT, h);
        queue_pixels(w * $urandom_range(h - 1, 3) + $urandom_range(w - 1, 1), 1'b1, 1'b0, 1'b0);
        settle();
        case ($urandom_range(2))
            0: write_register(CFG_WIDTH, $urandom_range(w - 1, MIN_GEOM));
            1: write_register(CFG_HEIGHT, MIN_GEOM);
            default: begin
                write_register(CFG_WIDTH, $urandom_range(w - 1, MIN_GEOM));
                write_register(CFG_HEIGHT, MIN_GEOM);
            end
        endcase
        queue_pixels($urandom_range(30, 10), 1'b0, 1'b0, 1'b0);
        settle();
    endtask

    // Starts a row at the widest setting, then narrows the frame mid-row so
    // the run stays short. The priming frame covers every column touched.
    task automatic wide_phase(input int raw_width);
        write_register(CFG_MODE, random_mode());
        write_register(CFG_WIDTH, PRIME_WIDTH);
        write_register(CFG_HEIGHT, MIN_GEOM);
        queue_pixels(PRIME_WIDTH * MIN_GEOM, 1'b1, 1'b0, 1'b0);
        settle();
        write_register(CFG_WIDTH, raw_width);
        queue_pixels($urandom_range(PRIME_WIDTH - 2, MIN_GEOM), 1'b1, 1'b0, 1'b0);
        settle();
        write_register(CFG_WIDTH, $urandom_range(5, MIN_GEOM));
        queue_pixels($urandom_range(24, 12), 1'b0, 1'b0, 1'b0);
        settle();
    endtask

    initial begin
        int phase;
        int m;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Narrowest and tallest frame: after two rows each new row of three
        // pixels yields one result, so every kernel gets its own row.
        set_idling();
        write_register(CFG_WIDTH, MIN_GEOM);
        write_register(CFG_HEIGHT, MAX_HEIGHT);
        write_register(CFG_MODE, MODE_BLUR);
        queue_pixels(3 * MIN_GEOM, 1'b1, 1'b1, 1'b0);
        settle();
        for (m = MODE_SHARPEN; m <= MODE_EMBOSS + 1; m++) begin
            write_register(CFG_MODE, (m > MODE_EMBOSS) ? MODE_CODES - 1 : m);
            queue_pixels(MIN_GEOM, 1'b0, 1'b1, 1'b0);
            settle();
        end

        phase = 0;
        while (queued_pixels < ITEM_TARGET) begin
            set_idling();
            if (phase == 2)
                wide_phase(MAX_WIDTH_DEF);
            else if (phase == 11)
                wide_phase((1 << GEOM_W) - 1);
            else if (phase % 7 == 4)
                shrink_phase();
            else
                random_phase();
            phase++;
        end
        settle();

        $display("Sent %0d pixels in %0d phases with %0d register writes;", accepted_pixels,
                 phase, register_writes);
        $display("checked %0d interior results across all kernels and geometries.",
                 checked_results);
        if (mismatches == 0)
            $display("rgb_3x3_kernel_convolution verification clean");
        else
            $display("rgb_3x3_kernel_convolution verification failed");
        $finish;
    end

endmodule
